>>> hdl/matrix_multiply_accumulate_macros.svh
// Assertion macros shared by the checker of the matrix multiply-accumulate block.
`ifndef MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge and off during reset.
`define MMA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("matrix multiply-accumulate: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge and off during reset.
`define MMA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("matrix multiply-accumulate: next-cycle check failed");

`endif

>>> hdl/mma_pkg.sv
// Shared types, codes and helpers of the matrix multiply-accumulate block.
`default_nettype none

package mma_pkg;

	localparam int MAX_DIM_DEF = 16;

	localparam int VAL_W = 32;
	localparam int PROD_W = 2 * VAL_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] MODE_LOAD_A = 2'd0;
	localparam logic [1:0] MODE_LOAD_B = 2'd1;
	localparam logic [1:0] MODE_C = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_M = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_N = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BETA = 3'd4;

	localparam logic [4:0] DIM_RST = 5'd16;
	localparam logic [VAL_W-1:0] ALPHA_RST = 32'h0001_0000;
	localparam logic [VAL_W-1:0] BETA_RST = 32'h0000_0000;

	// Half of one Q16.16 unit in a Q32.32 product.
	localparam logic [PROD_W-1:0] RND_HALF = 64'd32768;

	typedef enum logic [1:0] {
		TAG_DOT,
		TAG_BETA,
		TAG_ALPHA_LO,
		TAG_ALPHA_HI
	} tag_t;

	typedef struct packed {
		logic vld;
		tag_t tag;
		logic neg;
		logic [VAL_W-1:0] opa;
		logic [VAL_W-1:0] opb;
	} mul_req_t;

	typedef struct packed {
		logic vld;
		logic pend;
		tag_t tag;
		logic neg;
		logic [PROD_W-1:0] data;
	} mul_rsp_t;

	// Magnitude of a signed 32-bit word; the most negative value maps to 2^31.
	function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? (~v + 32'd1) : v;
	endfunction

endpackage

`default_nettype wire

>>> hdl/matrix_multiply_accumulate.sv
// A C item runs from the start edge to the done strobe; with inner_k of 0 the dot-product run is skipped.
// A and B loads leave busy low, and the next word is taken at once.
// A new C item is taken only after the last one is done; the work runs through the single shared multiplier
// that takes one dot-product term per cycle out of the two element memories.
// The done strobe lasts one cycle and cannot be held off; a new start may come in that cycle.
// Reset idles control and restores the configuration defaults; the A and B memories hold
// garbage until written.
`default_nettype none

module matrix_multiply_accumulate #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] mode,
	input wire logic [3:0] row,
	input wire logic [3:0] col,
	input wire logic signed [31:0] value,
	input wire logic wr_en,
	input wire logic [mma_pkg::CFG_IDX_W-1:0] wr_index,
	input wire logic [31:0] wr_data,
	output logic done,
	output logic [3:0] out_row,
	output logic [3:0] out_col,
	output logic signed [31:0] out_value,
	output logic saturated
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = ($clog2(MAX_DIM + 1) > 5) ? $clog2(MAX_DIM + 1) : 5;
	localparam int DOT_W = 48 + $clog2(MAX_DIM);
	localparam int SUM_W = 51;
	localparam int MAG_W = 49;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_LO,
		S_HI,
		S_BETA,
		S_WAIT,
		S_COMB1,
		S_COMB2,
		S_COMB3,
		S_OUT
	} state_t;

	state_t state_q;

	logic [4:0] rows_m_q, cols_n_q, inner_k_q;
	logic [31:0] alpha_q, beta_q;

	logic [CNT_W-1:0] eff_rows, eff_cols, eff_inner;
	logic [CNT_W-1:0] k_q, kn_q;
	logic [3:0] row_q, col_q;
	logic [31:0] c_q;

	logic [31:0] a_mem [DEPTH];
	logic [31:0] b_mem [DEPTH];
	logic [31:0] rd_a_q, rd_b_q;
	logic rd_vld_s1;
	logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

	logic accept, load_ok, take_c;
	logic drained;

	logic signed [DOT_W-1:0] acc_q;
	logic [DOT_W-1:0] acc_mag;
	logic [63:0] p_q, q_q;
	logic [63:0] lo_sum;
	logic [47:0] m_q;
	logic huge_q;
	logic [MAG_W-1:0] a_mag;
	logic a_neg;
	logic signed [SUM_W-1:0] aterm_q, bterm_q, total_q;
	logic sat_cond;

	mma_pkg::mul_req_t req;
	mma_pkg::mul_rsp_t rsp;

	always_comb begin
		eff_rows = (CNT_W'(rows_m_q) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(rows_m_q);
		eff_cols = (CNT_W'(cols_n_q) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(cols_n_q);
		eff_inner = (CNT_W'(inner_k_q) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM)
			: CNT_W'(inner_k_q);
	end

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign load_ok = (CNT_W'(row) < CNT_W'(MAX_DIM)) && (CNT_W'(col) < CNT_W'(MAX_DIM));
	assign take_c = accept && (mode == mma_pkg::MODE_C)
		&& (CNT_W'(row) < eff_rows) && (CNT_W'(col) < eff_cols);
	assign drained = !rd_vld_s1 && !rsp.pend && !rsp.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q <= mma_pkg::DIM_RST;
			cols_n_q <= mma_pkg::DIM_RST;
			inner_k_q <= mma_pkg::DIM_RST;
			alpha_q <= mma_pkg::ALPHA_RST;
			beta_q <= mma_pkg::BETA_RST;
		end else if (wr_en) begin
			case (wr_index)
				mma_pkg::REG_ROWS_M: rows_m_q <= wr_data[4:0];
				mma_pkg::REG_COLS_N: cols_n_q <= wr_data[4:0];
				mma_pkg::REG_INNER_K: inner_k_q <= wr_data[4:0];
				mma_pkg::REG_ALPHA: alpha_q <= wr_data;
				mma_pkg::REG_BETA: beta_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Element memories: one write port for loads, one registered read per cycle.
	assign wr_addr = ADDR_W'(int'(row) * MAX_DIM + int'(col));
	assign rd_addr_a = ADDR_W'(int'(row_q) * MAX_DIM + int'(k_q));
	assign rd_addr_b = ADDR_W'(int'(k_q) * MAX_DIM + int'(col_q));

	always_ff @(posedge clk) begin
		if (accept && load_ok && (mode == mma_pkg::MODE_LOAD_A)) begin
			a_mem[wr_addr] <= value;
		end
		rd_a_q <= a_mem[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (accept && load_ok && (mode == mma_pkg::MODE_LOAD_B)) begin
			b_mem[wr_addr] <= value;
		end
		rd_b_q <= b_mem[rd_addr_b];
	end

	assign acc_mag = acc_q[DOT_W-1] ? DOT_W'(-acc_q) : DOT_W'(acc_q);

	always_comb begin
		req.vld = rd_vld_s1;
		req.tag = mma_pkg::TAG_DOT;
		req.neg = rd_a_q[31] ^ rd_b_q[31];
		req.opa = mma_pkg::mag32(rd_a_q);
		req.opb = mma_pkg::mag32(rd_b_q);
		case (state_q)
			S_LO: begin
				req.vld = 1'b1;
				req.tag = mma_pkg::TAG_ALPHA_LO;
				req.neg = 1'b0;
				req.opa = mma_pkg::mag32(alpha_q);
				req.opb = acc_mag[31:0];
			end
			S_HI: begin
				req.vld = 1'b1;
				req.tag = mma_pkg::TAG_ALPHA_HI;
				req.neg = 1'b0;
				req.opa = mma_pkg::mag32(alpha_q);
				req.opb = 32'(acc_mag[DOT_W-1:32]);
			end
			S_BETA: begin
				req.vld = 1'b1;
				req.tag = mma_pkg::TAG_BETA;
				req.neg = beta_q[31] ^ c_q[31];
				req.opa = mma_pkg::mag32(beta_q);
				req.opb = mma_pkg::mag32(c_q);
			end
			default: ;
		endcase
	end

	mma_mulrnd u_mulrnd (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Alpha times dot: the high partial product must stay below 2^16, or the
	// term is far beyond range and is replaced by 2^48 with its sign.
	assign lo_sum = {q_q[15:0], 32'd0} + p_q + mma_pkg::RND_HALF;
	assign a_neg = alpha_q[31] ^ acc_q[DOT_W-1];
	assign a_mag = huge_q ? {1'b1, 48'd0} : {1'b0, m_q};
	assign sat_cond = !((&total_q[SUM_W-1:31]) || (~|total_q[SUM_W-1:31]));

	always_ff @(posedge clk) begin
		if (take_c) begin
			row_q <= row;
			col_q <= col;
			c_q <= value;
			kn_q <= eff_inner;
			acc_q <= '0;
		end else if (rsp.vld && (rsp.tag == mma_pkg::TAG_DOT)) begin
			acc_q <= rsp.neg ? acc_q - $signed(rsp.data[DOT_W-1:0])
				: acc_q + $signed(rsp.data[DOT_W-1:0]);
		end
		if (rsp.vld) begin
			case (rsp.tag)
				mma_pkg::TAG_BETA: bterm_q <= rsp.neg ? -$signed(SUM_W'(rsp.data[47:0]))
					: $signed(SUM_W'(rsp.data[47:0]));
				mma_pkg::TAG_ALPHA_LO: p_q <= rsp.data;
				mma_pkg::TAG_ALPHA_HI: q_q <= rsp.data;
				default: ;
			endcase
		end
		if (state_q == S_COMB1) begin
			m_q <= lo_sum[63:16];
			huge_q <= |q_q[63:16];
		end
		if (state_q == S_COMB2) begin
			aterm_q <= a_neg ? -$signed(SUM_W'(a_mag)) : $signed(SUM_W'(a_mag));
		end
		if (state_q == S_COMB3) begin
			total_q <= aterm_q + bterm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			rd_vld_s1 <= 1'b0;
			done <= 1'b0;
			out_row <= '0;
			out_col <= '0;
			out_value <= '0;
			saturated <= 1'b0;
		end else begin
			done <= 1'b0;
			rd_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (take_c) begin
						state_q <= (eff_inner == '0) ? S_DRAIN : S_RUN;
					end
				end
				S_RUN: begin
					rd_vld_s1 <= 1'b1;
					k_q <= k_q + 1'b1;
					if (k_q == kn_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (drained) begin
						state_q <= S_LO;
					end
				end
				S_LO: state_q <= S_HI;
				S_HI: state_q <= S_BETA;
				S_BETA: state_q <= S_WAIT;
				S_WAIT: begin
					if (drained) begin
						state_q <= S_COMB1;
					end
				end
				S_COMB1: state_q <= S_COMB2;
				S_COMB2: state_q <= S_COMB3;
				S_COMB3: state_q <= S_OUT;
				S_OUT: begin
					state_q <= S_IDLE;
					done <= 1'b1;
					out_row <= row_q;
					out_col <= col_q;
					saturated <= sat_cond;
					if (sat_cond) begin
						out_value <= total_q[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					end else begin
						out_value <= total_q[31:0];
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/mma_mulrnd.sv
// Shared multiply unit: magnitude product, optional Q16.16 rounding, three stages.
`default_nettype none

module mma_mulrnd (
	input wire logic clk,
	input wire logic arst_n,
	input wire mma_pkg::mul_req_t req,
	output mma_pkg::mul_rsp_t rsp
);

	logic vld_s2, vld_s3, vld_s4;
	mma_pkg::tag_t tag_s2, tag_s3, tag_s4;
	logic neg_s2, neg_s3, neg_s4;
	logic [mma_pkg::VAL_W-1:0] opa_s2, opb_s2;
	logic [mma_pkg::PROD_W-1:0] prod_s3, data_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= req.vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2 <= req.tag;
		neg_s2 <= req.neg;
		opa_s2 <= req.opa;
		opb_s2 <= req.opb;

		tag_s3 <= tag_s2;
		neg_s3 <= neg_s2;
		prod_s3 <= mma_pkg::PROD_W'(opa_s2) * mma_pkg::PROD_W'(opb_s2);

		tag_s4 <= tag_s3;
		neg_s4 <= neg_s3;
		// Dot terms and the beta term are rounded here; the alpha partial
		// products go out raw and are combined later.
		if (tag_s3 inside {mma_pkg::TAG_DOT, mma_pkg::TAG_BETA}) begin
			data_s4 <= (prod_s3 + mma_pkg::RND_HALF) >> 16;
		end else begin
			data_s4 <= prod_s3;
		end
	end

	assign rsp.vld = vld_s4;
	assign rsp.pend = vld_s2 | vld_s3;
	assign rsp.tag = tag_s4;
	assign rsp.neg = neg_s4;
	assign rsp.data = data_s4;

endmodule

`default_nettype wire

>>> hdl/mma_check.sv
// Port-level checker for the matrix multiply-accumulate block and its bind.
`default_nettype none

`include "matrix_multiply_accumulate_macros.svh"

module mma_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [1:0] mode,
	input wire logic done,
	input wire logic saturated,
	input wire logic [31:0] out_value
);

	// A result word closes a busy period and leaves the block ready for the next word.
	`MMA_ASSERT_IMP(a_done_ends_busy, clk, arst_n, done, !busy && $past(busy))

	// One C item gives one result word.
	`MMA_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)

	// Loads and unused modes finish in the cycle they are taken.
	`MMA_ASSERT_NXT(a_load_no_busy, clk, arst_n, start && !busy && (mode != mma_pkg::MODE_C), !busy)

	// A clipped result sits at one of the two range limits.
	`MMA_ASSERT_IMP(a_sat_limit, clk, arst_n, done && saturated, (out_value == 32'h7FFF_FFFF) || (out_value == 32'h8000_0000))

endmodule

bind matrix_multiply_accumulate mma_check u_mma_check (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.mode(mode),
	.done(done),
	.saturated(saturated),
	.out_value(out_value)
);

`default_nettype wire
